// File: hdl/rtip_pkg.sv
// ----------------------------------------------------------------------------
// rtip_pkg
// Shared types, constants and helper functions of the radix integer parser:
// parse state, pipeline payloads, character codes and digit decoding.
// ----------------------------------------------------------------------------
package rtip_pkg;

    // widths
    localparam int OFFSET_BITS = 16;
    localparam int ACC_BITS    = 64;
    localparam int END_BITS    = 16;
    localparam int RADIX_BITS  = 6;
    localparam int DIGIT_BITS  = 6;

    localparam logic [OFFSET_BITS-1:0] OFFSET_LIMIT = '1;
    localparam logic [OFFSET_BITS-1:0] OFFSET_ONE   = OFFSET_BITS'(1);

    // base selection codes
    localparam logic [RADIX_BITS-1:0] MODE_AUTO   = 6'd0;
    localparam logic [RADIX_BITS-1:0] BASE_OCT    = 6'd8;
    localparam logic [RADIX_BITS-1:0] BASE_DEC    = 6'd10;
    localparam logic [RADIX_BITS-1:0] BASE_HEX    = 6'd16;
    localparam logic [RADIX_BITS-1:0] RADIX_RESET = BASE_DEC;

    // character codes
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UZ    = 8'h5A;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LZ    = 8'h7A;
    localparam logic [7:0] CH_UX    = 8'h58;
    localparam logic [7:0] CH_LX    = 8'h78;
    localparam logic [7:0] LETTER_BIAS = 8'd10;

    typedef enum logic [2:0] {
        PH_SPACE,
        PH_SIGNED,
        PH_ZERO,
        PH_DIGITS,
        PH_DONE
    } phase_t;

    typedef struct packed {
        phase_t                   phase;
        logic                     negative;
        logic [ACC_BITS-1:0]      accum;
        logic [RADIX_BITS-1:0]    active_base;
        logic [OFFSET_BITS-1:0]   position;
        logic [OFFSET_BITS-1:0]   end_mark;
        logic                     have_digit;
    } parse_state_t;

    localparam parse_state_t CLEAR_STATE = '{
        phase:       PH_SPACE,
        negative:    1'b0,
        accum:       '0,
        active_base: '0,
        position:    '0,
        end_mark:    '0,
        have_digit:  1'b0
    };

    typedef struct packed {
        logic [7:0] ch;
        logic       start_req;
    } item_t;

    typedef struct packed {
        logic                  negative;
        logic [ACC_BITS-1:0]   accum;
        logic [END_BITS-1:0]   end_offset;
        logic                  done_res;
        logic                  digits_seen;
    } result_t;

    typedef struct packed {
        logic                  ok;
        logic [DIGIT_BITS-1:0] val;
    } digit_t;

    // digit value of a character, 0..35
    function automatic digit_t digit_of(input logic [7:0] c);
        digit_t d;
        d.ok  = 1'b1;
        d.val = '0;
        if (c inside {[CH_0:CH_9]})
            d.val = DIGIT_BITS'(c - CH_0);
        else if (c inside {[CH_LA:CH_LZ]})
            d.val = DIGIT_BITS'(c - CH_LA + LETTER_BIAS);
        else if (c inside {[CH_UA:CH_UZ]})
            d.val = DIGIT_BITS'(c - CH_UA + LETTER_BIAS);
        else
            d.ok = 1'b0;
        return d;
    endfunction

    // space, tab, newline, vertical tab, form feed, carriage return
    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || (c inside {[CH_TAB:CH_CR]});
    endfunction

    // offset reported on the result port, zero extended or truncated
    function automatic logic [END_BITS-1:0] to_end_offset(
        input logic [OFFSET_BITS-1:0] x
    );
        logic [OFFSET_BITS+END_BITS-1:0] ext;
        ext = {{END_BITS{1'b0}}, x};
        return ext[END_BITS-1:0];
    endfunction

endpackage

// File: hdl/radix_integer_text_parser.sv
// ----------------------------------------------------------------------------
// radix_integer_text_parser
// Streaming signed integer parser, one text byte per transfer.
// ----------------------------------------------------------------------------
// The parser takes one byte per clock while the result register is not
// stalled by res_ready, and returns one result per byte, passed through the
// input register, then the result register; the 64-bit by 6-bit
// multiply-add in the step logic updates the parse state. start_req
// marks the first byte of a string. Leading whitespace and one sign are
// skipped, base 0 detects octal, decimal or 0x hex, base 16 skips a 0x
// prefix, and the first byte that is not a digit of the base ends the number
// (done_res on that byte only; later bytes repeat the final result until the
// next start). radix_mode resets to 10 and may be written only while the
// parser is idle; it takes effect when the next number's base is resolved.
module radix_integer_text_parser
    import rtip_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_wr_en,
    input  logic [RADIX_BITS-1:0]      cfg_wr_data,
    input  logic                       item_valid,
    output logic                       item_ready,
    input  logic [7:0]                 ch,
    input  logic                       start_req,
    output logic                       res_valid,
    input  logic                       res_ready,
    output logic signed [ACC_BITS-1:0] value,
    output logic [END_BITS-1:0]        end_offset,
    output logic                       done_res,
    output logic                       digits_seen
);

    logic [RADIX_BITS-1:0] radix_mode_q_reg;
    parse_state_t          state_reg;
    parse_state_t          state_next;
    logic                  stage_valid;
    item_t                 stage_item;
    result_t               result;
    logic                  out_free;
    logic                  advance;

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            radix_mode_q_reg <= RADIX_RESET;
        else if (cfg_wr_en)
            radix_mode_q_reg <= cfg_wr_data;
    end

    // held byte moves into the result register
    assign advance = stage_valid && out_free;

    rtip_in_reg u_in_reg (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_ready  (item_ready),
        .ch          (ch),
        .start_req   (start_req),
        .advance     (advance),
        .stage_valid (stage_valid),
        .stage_item  (stage_item)
    );

    rtip_step u_step (
        .cur_state  (state_reg),
        .item       (stage_item),
        .radix_mode (radix_mode_q_reg),
        .state_next (state_next),
        .result     (result)
    );

    // parse state, updated once per byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= CLEAR_STATE;
        else if (advance)
            state_reg <= state_next;
    end

    rtip_out_reg u_out_reg (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (advance),
        .result      (result),
        .out_free    (out_free),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .value       (value),
        .end_offset  (end_offset),
        .done_res    (done_res),
        .digits_seen (digits_seen)
    );

endmodule

// File: hdl/rtip_in_reg.sv
// ----------------------------------------------------------------------------
// rtip_in_reg
// Input register of the parser: captures one text byte per transfer and
// holds it until the step logic consumes it.
// ----------------------------------------------------------------------------
module rtip_in_reg
    import rtip_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  item_valid,
    output logic  item_ready,
    input  logic  [7:0] ch,
    input  logic  start_req,
    input  logic  advance,
    output logic  stage_valid,
    output item_t stage_item
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;
    logic  accept;

    // free when empty or when the held byte moves on this cycle
    assign item_ready = !valid_reg || advance;
    assign accept     = item_valid && item_ready;

    always_comb
    begin
        if (accept)
            valid_next = 1'b1;
        else if (advance)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // payload capture
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.ch        <= ch;
            item_reg.start_req <= start_req;
        end
    end

    assign stage_valid = valid_reg;
    assign stage_item  = item_reg;

endmodule

// File: hdl/rtip_step.sv
// ----------------------------------------------------------------------------
// rtip_step
// Single-pass step logic: from the current parse state and one text byte,
// forms the next parse state and the result of that byte.
// ----------------------------------------------------------------------------
module rtip_step
    import rtip_pkg::*;
(
    input  parse_state_t          cur_state,
    input  item_t                 item,
    input  logic [RADIX_BITS-1:0] radix_mode,
    output parse_state_t          state_next,
    output result_t               result
);

    parse_state_t             s;
    parse_state_t             nxt;
    phase_t                   phase_next;
    logic [OFFSET_BITS-1:0]   at;
    logic [OFFSET_BITS-1:0]   pos_inc;
    logic                     is_sp;
    logic                     is_plus;
    logic                     is_minus;
    logic                     is_x;
    logic                     begin_num;
    logic                     zero_pref;
    logic [RADIX_BITS-1:0]    begin_base;
    logic                     take;
    logic [RADIX_BITS-1:0]    take_base;
    digit_t                   dig;
    logic                     dig_ok;
    logic [ACC_BITS-1:0]      product;
    logic [ACC_BITS-1:0]      mul_add;
    logic                     done_now;
    phase_t                   take_phase;

    // a start transfer restarts the parse on this very byte
    assign s = item.start_req ? CLEAR_STATE : cur_state;

    // saturating position
    assign at      = s.position;
    assign pos_inc = (at != OFFSET_LIMIT) ? at + OFFSET_ONE : OFFSET_LIMIT;

    // character classes
    assign is_sp    = is_space(item.ch);
    assign is_plus  = item.ch == CH_PLUS;
    assign is_minus = item.ch == CH_MINUS;
    assign is_x     = (item.ch == CH_LX) || (item.ch == CH_UX);

    // first byte of the number proper
    assign begin_num = ((s.phase == PH_SPACE) && !is_sp && !is_plus && !is_minus)
                       || (s.phase == PH_SIGNED);
    assign zero_pref  = (item.ch == CH_0)
                        && ((radix_mode == MODE_AUTO) || (radix_mode == BASE_HEX));
    assign begin_base = (radix_mode == MODE_AUTO) ? BASE_DEC : radix_mode;

    // bytes that go through the digit path
    assign take = (begin_num && !zero_pref)
                  || ((s.phase == PH_ZERO) && !is_x)
                  || (s.phase == PH_DIGITS);
    assign take_base = ((s.phase == PH_ZERO) || (s.phase == PH_DIGITS))
                       ? s.active_base : begin_base;

    assign dig    = digit_of(item.ch);
    assign dig_ok = dig.ok && (dig.val < take_base);

    // multiply-add; after a lone leading zero the accumulator is still zero,
    // so the implied '0' digit needs no second multiply
    assign product = s.accum * ACC_BITS'(take_base);
    assign mul_add = product + ACC_BITS'(dig.val);

    assign take_phase = dig_ok ? PH_DIGITS : PH_DONE;

    // next phase
    always_comb
    begin
        case (s.phase)
            PH_SPACE:
            begin
                if (is_sp)
                    phase_next = PH_SPACE;
                else if (is_plus || is_minus)
                    phase_next = PH_SIGNED;
                else if (zero_pref)
                    phase_next = PH_ZERO;
                else
                    phase_next = take_phase;
            end
            PH_SIGNED:
                phase_next = zero_pref ? PH_ZERO : take_phase;
            PH_ZERO:
                phase_next = is_x ? PH_DIGITS : take_phase;
            PH_DIGITS:
                phase_next = take_phase;
            PH_DONE:
                phase_next = PH_DONE;
            default:
                phase_next = s.phase;
        endcase
    end

    // parse datapath
    always_comb
    begin
        nxt      = s;
        done_now = 1'b0;
        if (s.phase != PH_DONE)
        begin
            nxt.position = pos_inc;
            nxt.end_mark = pos_inc;
            if ((s.phase == PH_SPACE) && is_minus)
                nxt.negative = 1'b1;
            if (begin_num && zero_pref)
                nxt.active_base = (radix_mode == MODE_AUTO) ? BASE_OCT : BASE_HEX;
            if ((s.phase == PH_ZERO) && is_x)
                nxt.active_base = BASE_HEX;
            if (take)
            begin
                nxt.active_base = take_base;
                // the held zero counts as a digit
                if (s.phase == PH_ZERO)
                    nxt.have_digit = 1'b1;
                if (dig_ok)
                begin
                    nxt.accum      = mul_add;
                    nxt.have_digit = 1'b1;
                end
                else
                begin
                    nxt.end_mark = at;
                    done_now     = 1'b1;
                end
            end
        end
        nxt.phase = phase_next;
    end

    assign state_next = nxt;

    // result of this byte
    assign result.negative    = nxt.negative;
    assign result.accum       = nxt.accum;
    assign result.end_offset  = to_end_offset(nxt.end_mark);
    assign result.done_res    = done_now;
    assign result.digits_seen = nxt.have_digit;

endmodule

// File: hdl/rtip_out_reg.sv
// ----------------------------------------------------------------------------
// rtip_out_reg
// Result register of the parser: holds one result until its transfer and
// applies the sign to the accumulated magnitude.
// ----------------------------------------------------------------------------
module rtip_out_reg
    import rtip_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       load,
    input  result_t                    result,
    output logic                       out_free,
    output logic                       res_valid,
    input  logic                       res_ready,
    output logic signed [ACC_BITS-1:0] value,
    output logic [END_BITS-1:0]        end_offset,
    output logic                       done_res,
    output logic                       digits_seen
);

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    // room for a new result when empty or when the held one leaves now
    assign out_free = !valid_reg || res_ready;

    always_comb
    begin
        if (load)
            valid_next = 1'b1;
        else if (res_ready)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            res_reg <= result;
    end

    // sign applied in two's complement, wrapping
    assign value = signed'(res_reg.negative
                           ? ({ACC_BITS{1'b0}} - res_reg.accum)
                           : res_reg.accum);

    assign res_valid   = valid_reg;
    assign end_offset  = res_reg.end_offset;
    assign done_res    = res_reg.done_res;
    assign digits_seen = res_reg.digits_seen;

endmodule

// File: hdl/rtip_checker.sv
// ----------------------------------------------------------------------------
// rtip_checker
// Port-level checks of the parser: results only for accepted bytes, bounded
// occupancy, stable held results and quiet reset.
// ----------------------------------------------------------------------------
module rtip_checker
    import rtip_pkg::*;
(
    input logic                       clk,
    input logic                       rst_n,
    input logic                       item_valid,
    input logic                       item_ready,
    input logic                       res_valid,
    input logic                       res_ready,
    input logic signed [ACC_BITS-1:0] value,
    input logic [END_BITS-1:0]        end_offset,
    input logic                       done_res,
    input logic                       digits_seen
);

    logic [1:0] inflight_reg;
    logic [1:0] inflight_next;
    logic       in_xfer;
    logic       out_xfer;

    assign in_xfer  = item_valid && item_ready;
    assign out_xfer = res_valid && res_ready;

    // bytes accepted whose result has not been transferred
    always_comb
    begin
        inflight_next = inflight_reg;
        if (in_xfer && !out_xfer)
            inflight_next = inflight_reg + 2'd1;
        else if (!in_xfer && out_xfer)
            inflight_next = inflight_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            inflight_reg <= 2'd0;
        else
            inflight_reg <= inflight_next;
    end

    // no result without an accepted byte behind it
    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> inflight_reg != 2'd0)
        else $error("result shown with no byte in flight");

    // two registers hold at most two bytes
    a_occupancy: assert property (@(posedge clk) disable iff (!rst_n)
        inflight_reg != 2'd3)
        else $error("more than two bytes in flight");

    // a stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(value)
            && $stable(end_offset) && $stable(done_res) && $stable(digits_seen))
        else $error("stalled result changed");

    // nothing offered once reset has been seen at an edge
    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |=> !res_valid)
        else $error("result valid during reset");

endmodule

bind radix_integer_text_parser rtip_checker u_rtip_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .item_valid  (item_valid),
    .item_ready  (item_ready),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .value       (value),
    .end_offset  (end_offset),
    .done_res    (done_res),
    .digits_seen (digits_seen)
);

// File: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Checks the streaming integer parser one byte at a time. A queue of text
// bytes feeds a valid/ready driver with random gaps. A parse predictor turns
// every accepted byte into the expected value, end offset, done flag and
// digit flag. A monitor with random back-pressure compares each result
// transfer against the oldest prediction. Directed strings cover signs,
// prefixes and odd bases. Random phases at varied radix settings follow.
// ----------------------------------------------------------------------------
module testbench;
    import rtip_pkg::*;

    localparam int                    QUIET_LIMIT = 2000;
    localparam int                    DRAIN_WAIT  = 4;
    localparam logic [7:0]            NOT_DIGIT   = 8'hFF;
    localparam logic [RADIX_BITS-1:0] RADIX_UNARY = 6'd1;
    localparam logic [RADIX_BITS-1:0] RADIX_ALNUM = 6'd36;
    localparam logic [RADIX_BITS-1:0] RADIX_TOP   = 6'd63;

    typedef struct packed {
        logic [ACC_BITS-1:0] value;
        logic [END_BITS-1:0] offset;
        logic                done;
        logic                digits;
    } parse_result_t;

    logic                       clk         = 1'b0;
    logic                       rst_n       = 1'b0;
    logic                       cfg_wr_en   = 1'b0;
    logic [RADIX_BITS-1:0]      cfg_wr_data = '0;
    logic                       item_valid  = 1'b0;
    logic                       item_ready;
    logic [7:0]                 ch          = '0;
    logic                       start_req   = 1'b0;
    logic                       res_valid;
    logic                       res_ready   = 1'b0;
    logic signed [ACC_BITS-1:0] value;
    logic [END_BITS-1:0]        end_offset;
    logic                       done_res;
    logic                       digits_seen;

    // text bytes waiting to be sent, predicted results waiting to arrive
    item_t         text_q[$];
    parse_result_t parse_q[$];

    // predictor state, starting from the reset state
    logic [RADIX_BITS-1:0]  radix_sel   = BASE_DEC;
    phase_t                 ps_phase    = PH_SPACE;
    logic                   ps_negative = 1'b0;
    logic [ACC_BITS-1:0]    ps_accum    = '0;
    logic [RADIX_BITS-1:0]  ps_base     = '0;
    logic [OFFSET_BITS-1:0] ps_pos      = '0;
    logic [OFFSET_BITS-1:0] ps_end      = '0;
    logic                   ps_digit    = 1'b0;
    logic                   ps_done     = 1'b0;

    int bad_count    = 0;
    int quiet_cycles = 0;
    int queued_bytes = 0;
    int send_gap     = 0;
    int stall_left   = 0;
    bit steady       = 1'b0;

    radix_integer_text_parser dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .item_valid  (item_valid),
        .item_ready  (item_ready),
        .ch          (ch),
        .start_req   (start_req),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .value       (value),
        .end_offset  (end_offset),
        .done_res    (done_res),
        .digits_seen (digits_seen)
    );

    // clock
    initial
    begin
        forever #5 clk = ~clk;
    end

    // idle length: mostly none or short, now and then long
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    // accept one digit of the resolved base, or end the number here
    task automatic take_digit(input logic [7:0] c, input logic [OFFSET_BITS-1:0] at);
        logic [7:0] d;
        if (c >= CH_0 && c <= CH_9)
            d = c - CH_0;
        else if (c >= CH_LA && c <= CH_LZ)
            d = c - CH_LA + LETTER_BIAS;
        else if (c >= CH_UA && c <= CH_UZ)
            d = c - CH_UA + LETTER_BIAS;
        else
            d = NOT_DIGIT;
        if (d < 8'(ps_base))
        begin
            ps_accum = ps_accum * 64'(ps_base) + 64'(d);
            ps_digit = 1'b1;
        end
        else
        begin
            ps_phase = PH_DONE;
            ps_end   = at;
            ps_done  = 1'b1;
        end
    endtask

    // first byte after whitespace and sign resolves the base
    task automatic begin_number(input logic [7:0] c, input logic [OFFSET_BITS-1:0] at);
        if (c == CH_0 && (radix_sel == MODE_AUTO || radix_sel == BASE_HEX))
        begin
            ps_base  = (radix_sel == MODE_AUTO) ? BASE_OCT : BASE_HEX;
            ps_phase = PH_ZERO;
        end
        else
        begin
            ps_base  = (radix_sel == MODE_AUTO) ? BASE_DEC : radix_sel;
            ps_phase = PH_DIGITS;
            take_digit(c, at);
        end
    endtask

    // advance the parse by one accepted byte and queue its result
    task automatic parse_byte(input logic [7:0] c, input logic first);
        logic [OFFSET_BITS-1:0] at;
        parse_result_t          r;
        if (first)
        begin
            ps_phase    = PH_SPACE;
            ps_negative = 1'b0;
            ps_accum    = '0;
            ps_base     = '0;
            ps_pos      = '0;
            ps_end      = '0;
            ps_digit    = 1'b0;
        end
        ps_done = 1'b0;
        at      = ps_pos;
        if (ps_phase != PH_DONE)
        begin
            ps_pos = (at < OFFSET_LIMIT) ? at + OFFSET_ONE : OFFSET_LIMIT;
            ps_end = ps_pos;
            case (ps_phase)
                PH_SPACE:
                begin
                    if (!(c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)))
                    begin
                        if (c == CH_PLUS)
                            ps_phase = PH_SIGNED;
                        else if (c == CH_MINUS)
                        begin
                            ps_negative = 1'b1;
                            ps_phase    = PH_SIGNED;
                        end
                        else
                            begin_number(c, at);
                    end
                end
                PH_SIGNED:
                    begin_number(c, at);
                PH_ZERO:
                begin
                    if (c == CH_LX || c == CH_UX)
                    begin
                        ps_base  = BASE_HEX;
                        ps_phase = PH_DIGITS;
                    end
                    else
                    begin
                        take_digit(CH_0, at);
                        ps_phase = PH_DIGITS;
                        take_digit(c, at);
                    end
                end
                default:
                    take_digit(c, at);
            endcase
        end
        r.value  = ps_negative ? -ps_accum : ps_accum;
        r.offset = END_BITS'(ps_end);
        r.done   = ps_done;
        r.digits = ps_digit;
        parse_q.push_back(r);
    endtask

    // byte driver
    always @(posedge clk or negedge rst_n)
    begin : text_driver
        item_t next_byte;
        if (!rst_n)
        begin
            item_valid <= 1'b0;
        end
        else
        begin
            if (item_valid && item_ready)
                parse_byte(ch, start_req);
            if (!item_valid || item_ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    item_valid <= 1'b0;
                end
                else if (text_q.size() > 0)
                begin
                    next_byte  = text_q.pop_front();
                    ch         <= next_byte.ch;
                    start_req  <= next_byte.start_req;
                    item_valid <= 1'b1;
                    send_gap   = gap_len();
                end
                else
                begin
                    item_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor with random back-pressure
    always @(posedge clk or negedge rst_n)
    begin : result_monitor
        parse_result_t want;
        if (!rst_n)
        begin
            res_ready <= 1'b0;
        end
        else
        begin
            if (res_valid && res_ready)
            begin
                if (parse_q.size() == 0)
                begin
                    bad_count++;
                    if (bad_count <= 10)
                        $display("unexpected result: value %h offset %0d done %b digits %b",
                                 value, end_offset, done_res, digits_seen);
                end
                else
                begin
                    want = parse_q.pop_front();
                    if (value !== want.value || end_offset !== want.offset ||
                        done_res !== want.done || digits_seen !== want.digits)
                    begin
                        bad_count++;
                        if (bad_count <= 10)
                            $display({"mismatch: value %h/%h offset %0d/%0d done %b/%b",
                                      " digits %b/%b (expected/actual)"},
                                     want.value, value, want.offset, end_offset,
                                     want.done, done_res, want.digits, digits_seen);
                    end
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                res_ready <= 1'b0;
            end
            else
            begin
                res_ready <= 1'b1;
                if (!steady && $urandom_range(0, 3) == 0)
                    stall_left = gap_len();
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin : watchdog
        if ((item_valid && item_ready) || (res_valid && res_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("FAIL radix_integer_text_parser");
            $finish;
        end
    end

    task automatic push_byte(input logic [7:0] c, input logic first);
        item_t it;
        it.ch        = c;
        it.start_req = first;
        text_q.push_back(it);
        queued_bytes++;
    endtask

    task automatic push_text(input string s, input logic first);
        for (int i = 0; i < s.len(); i++)
            push_byte(s[i], first && (i == 0));
    endtask

    // wait until every byte is sent and every result has come back
    task automatic wait_drained();
        @(negedge clk);
        while (text_q.size() != 0 || item_valid || parse_q.size() != 0)
            @(negedge clk);
    endtask

    task automatic set_radix(input logic [RADIX_BITS-1:0] r);
        wait_drained();
        repeat (DRAIN_WAIT) @(posedge clk);
        cfg_wr_data <= r;
        cfg_wr_en   <= 1'b1;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        radix_sel   = r;
    endtask

    // one random string: mostly well formed, sometimes plain noise
    task automatic gen_number();
        logic       lead;
        logic [7:0] c;
        int         eff;
        int         pf;
        int         n;
        lead = ($urandom_range(0, 19) != 0);
        if ($urandom_range(0, 6) == 0)
        begin
            n = $urandom_range(1, 8);
            for (int i = 0; i < n; i++)
            begin
                push_byte(8'($urandom_range(0, 255)), lead);
                lead = 1'b0;
            end
            return;
        end
        // leading whitespace and sign
        n = $urandom_range(0, 3);
        for (int i = 0; i < n; i++)
        begin
            c = ($urandom_range(0, 5) == 0) ? CH_SPACE : 8'($urandom_range(CH_TAB, CH_CR));
            push_byte(c, lead);
            lead = 1'b0;
        end
        case ($urandom_range(0, 2))
            0: begin push_byte(CH_PLUS, lead); lead = 1'b0; end
            1: begin push_byte(CH_MINUS, lead); lead = 1'b0; end
            default: ;
        endcase
        // optional prefix
        pf = $urandom_range(0, 5);
        if (pf == 0)
        begin
            push_byte(CH_0, lead);
            push_byte($urandom_range(0, 1) ? CH_LX : CH_UX, 1'b0);
            lead = 1'b0;
        end
        else if (pf == 1)
        begin
            push_byte(CH_0, lead);
            lead = 1'b0;
        end
        if (radix_sel == MODE_AUTO)
            eff = (pf == 0) ? 16 : (pf == 1) ? 8 : 10;
        else
            eff = (radix_sel > RADIX_ALNUM) ? 36 : int'(radix_sel);
        // digits of the base, long runs wrap the accumulator
        n = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 2) : $urandom_range(1, 22);
        for (int i = 0; i < n; i++)
        begin
            pf = $urandom_range(0, eff - 1);
            if (pf < 10)
                c = CH_0 + 8'(pf);
            else
                c = ($urandom_range(0, 1) ? CH_LA : CH_UA) + 8'(pf - 10);
            push_byte(c, lead);
            lead = 1'b0;
        end
        // terminator and trailing bytes that should be ignored
        case ($urandom_range(0, 2))
            0: push_byte(CH_SPACE, lead);
            1: push_byte(8'($urandom_range(0, 255)), lead);
            default: ;
        endcase
        n = $urandom_range(0, 2);
        for (int i = 0; i < n; i++)
            push_byte(8'($urandom_range(0, 255)), 1'b0);
    endtask

    // stimulus
    initial
    begin : stimulus
        logic [RADIX_BITS-1:0] pick;
        int                    mark;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // reset radix, no start flag on the first string, bytes after done
        push_text("-12;", 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(8'h00, 1'b0);
        // no digits after whitespace and sign, every whitespace code
        push_text(" \t+z", 1'b1);
        push_text("\n\013\014\015 9", 1'b1);

        // auto detection: hex, octal, bare prefix, octal stops at 9
        set_radix(MODE_AUTO);
        push_text("0x1F ", 1'b1);
        push_text("-017 ", 1'b1);
        push_text("0xg", 1'b1);
        push_text("09", 1'b1);

        set_radix(BASE_HEX);
        push_text("0XfF!", 1'b1);
        push_text("-Ab,", 1'b1);
        // base not resolved yet when the radix changes
        push_text(" -", 1'b1);
        set_radix(MODE_AUTO);
        push_text("0x5 ", 1'b0);

        set_radix(RADIX_UNARY);
        push_text("001 ", 1'b1);
        set_radix(RADIX_TOP);
        push_text("zZ9.", 1'b1);
        set_radix(RADIX_ALNUM);
        push_text("Zz-", 1'b1);

        // base already resolved when the radix changes
        set_radix(BASE_DEC);
        push_text("12", 1'b1);
        set_radix(BASE_HEX);
        push_text("ab ", 1'b0);

        // random phases over a spread of radix settings
        for (int p = 0; p < 14; p++)
        begin
            case ($urandom_range(0, 7))
                0: pick = MODE_AUTO;
                1: pick = BASE_DEC;
                2: pick = BASE_HEX;
                3: pick = BASE_OCT;
                4: pick = RADIX_UNARY;
                5: pick = RADIX_ALNUM;
                6: pick = RADIX_TOP;
                default: pick = 6'($urandom_range(2, 62));
            endcase
            if (p < 2)
                pick = (p == 0) ? MODE_AUTO : BASE_HEX;
            set_radix(pick);
            steady = ($urandom_range(0, 3) == 0);
            mark   = queued_bytes;
            while (queued_bytes - mark < 125)
                gen_number();
        end

        wait_drained();
        repeat (8) @(posedge clk);
        if (bad_count == 0 && parse_q.size() == 0)
            $display("PASS radix_integer_text_parser");
        else
            $display("FAIL radix_integer_text_parser");
        $finish;
    end

endmodule

// File: files.f
hdl/rtip_pkg.sv
hdl/rtip_in_reg.sv
hdl/rtip_step.sv
hdl/rtip_out_reg.sv
hdl/radix_integer_text_parser.sv
hdl/rtip_checker.sv
tb/sv/testbench.sv
